FILE: rtl/nalsc_pkg.sv
// nalsc_pkg: shared types and constants for the start code gate
// no dependencies
package nalsc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MatchW  = 2;
  localparam int unsigned PosW    = 3;
  localparam int unsigned CodeLen = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [MatchW-1:0] MatchLast = 2'd3;
  localparam logic [PosW-1:0]   HeaderPos = 3'd4;
  localparam logic [PosW-1:0]   PosMax    = 3'd5;

  localparam logic [ByteW-1:0] CodeZero = 8'h00;
  localparam logic [ByteW-1:0] CodeOne  = 8'h01;

  localparam logic [ByteW-1:0] PpsReset = 8'h28;
  localparam logic [ByteW-1:0] SpsReset = 8'h27;

  localparam logic [CfgIdxW-1:0] CfgPps = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSps = 1'b1;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ByteW-1:0] data;
  } gate_res_t;

endpackage

FILE: rtl/nalsc_matcher.sv
// nalsc_matcher: naive start code matcher with armed flag
// depends on nalsc_pkg
module nalsc_matcher (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [nalsc_pkg::ByteW-1:0] byte_i,
  output logic                       closes_o
);

  logic [nalsc_pkg::MatchW-1:0] match_q, match_d;
  logic                         armed_q, armed_d;
  logic [nalsc_pkg::ByteW-1:0]  expect_byte;
  logic                         hit;
  logic                         code_done;

  always_comb begin
    expect_byte = (match_q == nalsc_pkg::MatchLast) ? nalsc_pkg::CodeOne : nalsc_pkg::CodeZero;
    hit         = (byte_i == expect_byte);
    code_done   = hit && (match_q == nalsc_pkg::MatchLast);
    closes_o    = code_done && armed_q;
    if (!hit || code_done) begin
      match_d = '0;
    end else begin
      match_d = match_q + 2'd1;
    end
    armed_d = armed_q || code_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      armed_q <= 1'b0;
    end else if (adv_i) begin
      match_q <= match_d;
      armed_q <= armed_d;
    end
  end

  // a closing start code always ends in the one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    closes_o |-> (byte_i == nalsc_pkg::CodeOne) && armed_q)
    else $error("close without full start code");

endmodule

FILE: rtl/nalsc_gate.sv
// nalsc_gate: delay line, unit position, header capture and pass decision
// depends on nalsc_pkg
module nalsc_gate (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [nalsc_pkg::ByteW-1:0] byte_i,
  input  logic                        closes_i,
  input  logic [nalsc_pkg::ByteW-1:0] pps_header_i,
  input  logic [nalsc_pkg::ByteW-1:0] sps_header_i,
  output nalsc_pkg::gate_res_t        res_o
);

  logic [nalsc_pkg::ByteW-1:0] dline_q [nalsc_pkg::CodeLen];
  logic [nalsc_pkg::PosW-1:0]  pos_q, pos_d;
  logic [nalsc_pkg::ByteW-1:0] header_q, header_d;
  logic                        pps_seen_q, pps_seen_d;
  logic                        sps_seen_q, sps_seen_d;
  logic                        leaving;
  logic                        passes;

  always_comb begin
    leaving  = (pos_q >= nalsc_pkg::HeaderPos);
    header_d = (pos_q == nalsc_pkg::HeaderPos) ? byte_i : header_q;
    passes   = (pps_seen_q && sps_seen_q)
            || ((header_d == pps_header_i) && !pps_seen_q)
            || ((header_d == sps_header_i) && !sps_seen_q);

    res_o.emit = leaving && passes;
    res_o.last = closes_i;
    res_o.data = dline_q[0];

    pps_seen_d = pps_seen_q;
    sps_seen_d = sps_seen_q;
    pos_d      = pos_q;
    if (closes_i) begin
      if (header_d == pps_header_i) pps_seen_d = 1'b1;
      if (header_d == sps_header_i) sps_seen_d = 1'b1;
      pos_d = nalsc_pkg::HeaderPos;
    end else if (pos_q < nalsc_pkg::PosMax) begin
      pos_d = pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      header_q   <= '0;
      pps_seen_q <= 1'b0;
      sps_seen_q <= 1'b0;
    end else if (adv_i) begin
      pos_q      <= pos_d;
      header_q   <= header_d;
      pps_seen_q <= pps_seen_d;
      sps_seen_q <= sps_seen_d;
    end
  end

  // delay line, oldest first
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < nalsc_pkg::CodeLen - 1; k++) begin
        dline_q[k] <= dline_q[k+1];
      end
      dline_q[nalsc_pkg::CodeLen-1] <= byte_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= nalsc_pkg::PosMax)
    else $error("unit position out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && closes_i |=> pos_q == nalsc_pkg::HeaderPos)
    else $error("closed unit did not reopen at header position");

endmodule

FILE: rtl/nal_unit_start_code_gate.sv
// nal_unit_start_code_gate: start code parser that gates units on parameter sets
// path: a byte passes the input register, the gate delay line and the result register
// throughput: one item per cycle while the output accepts; the input and result registers set the pace
// reset: asynchronous active-low, clears matcher, unit state and valid flags
// depends on nalsc_pkg, nalsc_matcher, nalsc_gate
module nal_unit_start_code_gate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [nalsc_pkg::ByteW-1:0]   s_axis_tdata_i,  // [7:0] data_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [nalsc_pkg::ByteW-1:0]   m_axis_tdata_o,  // [7:0] out_byte
  output logic                          m_axis_tlast_o,  // unit_end
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nalsc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [nalsc_pkg::ByteW-1:0]   cfg_data_i
);

  logic                        in_valid_q;
  logic [nalsc_pkg::ByteW-1:0] in_byte_q;
  logic                        out_valid_q;
  logic [nalsc_pkg::ByteW-1:0] out_byte_q;
  logic                        out_last_q;
  logic [nalsc_pkg::ByteW-1:0] pps_header_q;
  logic [nalsc_pkg::ByteW-1:0] sps_header_q;
  logic                        adv;
  logic                        closes;
  nalsc_pkg::gate_res_t        res;

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pps_header_q <= nalsc_pkg::PpsReset;
      sps_header_q <= nalsc_pkg::SpsReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nalsc_pkg::CfgPps: pps_header_q <= cfg_data_i;
        nalsc_pkg::CfgSps: sps_header_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  nalsc_matcher u_matcher (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .byte_i   (in_byte_q),
    .closes_o (closes)
  );

  nalsc_gate u_gate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .byte_i       (in_byte_q),
    .closes_i     (closes),
    .pps_header_i (pps_header_q),
    .sps_header_i (sps_header_q),
    .res_o        (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res.emit;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.emit) begin
      out_byte_q <= res.data;
      out_last_q <= res.last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while both registers are full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res.emit && res.last |=> m_axis_tvalid_o && m_axis_tlast_o)
    else $error("unit end lost at result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res.emit && res.last |-> in_byte_q == nalsc_pkg::CodeOne)
    else $error("unit end without start code byte");

endmodule

FILE: test/testbench.sv
// testbench for nal_unit_start_code_gate: random byte streams with start codes, checked
// against a built-in parser of the same unit gating, under several idle mixes
// depends on nalsc_pkg and the nal_unit_start_code_gate rtl
module testbench;

  localparam int SettleCycles = 8;
  localparam int StallLimit   = 2000;

  typedef logic [nalsc_pkg::ByteW-1:0] byte_t;

  typedef struct {
    logic [nalsc_pkg::ByteW-1:0] data;
    logic                        unit_end;
  } out_byte_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [nalsc_pkg::ByteW-1:0]   s_axis_tdata_i = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [nalsc_pkg::ByteW-1:0]   m_axis_tdata_o;
  logic                          m_axis_tlast_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [nalsc_pkg::CfgIdxW-1:0] cfg_index_i = nalsc_pkg::CfgPps;
  logic [nalsc_pkg::ByteW-1:0]   cfg_data_i = '0;

  // stream bytes waiting to be sent, unit bytes the gate should pass
  logic [nalsc_pkg::ByteW-1:0] byte_q[$];
  out_byte_t                   passed_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bad_cnt        = 0;
  int stall_cycles   = 0;

  // parser state as the gate should hold it
  logic [nalsc_pkg::ByteW-1:0]  pps_reg = nalsc_pkg::PpsReset;
  logic [nalsc_pkg::ByteW-1:0]  sps_reg = nalsc_pkg::SpsReset;
  logic [nalsc_pkg::MatchW-1:0] match_cnt = '0;
  logic                         armed = 1'b0;
  logic                         pps_seen = 1'b0;
  logic                         sps_seen = 1'b0;
  logic [nalsc_pkg::ByteW-1:0]  dline [nalsc_pkg::CodeLen] = '{default: '0};
  logic [nalsc_pkg::PosW-1:0]   pos_cnt = '0;
  logic [nalsc_pkg::ByteW-1:0]  unit_hdr = '0;
  out_byte_t                    head_b;

  nal_unit_start_code_gate dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void parse_byte(input logic [nalsc_pkg::ByteW-1:0] b);
    logic                        leaving;
    logic                        closes;
    logic [nalsc_pkg::ByteW-1:0] want;
    out_byte_t                   ob;
    leaving = pos_cnt >= nalsc_pkg::HeaderPos;
    closes  = 1'b0;
    if (pos_cnt == nalsc_pkg::HeaderPos) unit_hdr = b;
    want = (match_cnt == nalsc_pkg::MatchLast) ? nalsc_pkg::CodeOne : nalsc_pkg::CodeZero;
    if (b != want) begin
      match_cnt = '0;
    end else if (match_cnt != nalsc_pkg::MatchLast) begin
      match_cnt = match_cnt + 1'b1;
    end else begin
      match_cnt = '0;
      if (armed) closes = 1'b1;
      else armed = 1'b1;
    end
    if (leaving && ((pps_seen && sps_seen) || (unit_hdr == pps_reg && !pps_seen) ||
                    (unit_hdr == sps_reg && !sps_seen))) begin
      ob.data     = dline[0];
      ob.unit_end = closes;
      passed_q.push_back(ob);
    end
    for (int k = 0; k < nalsc_pkg::CodeLen - 1; k++) dline[k] = dline[k + 1];
    dline[nalsc_pkg::CodeLen - 1] = b;
    if (closes) begin
      if (unit_hdr == pps_reg) pps_seen = 1'b1;
      if (unit_hdr == sps_reg) sps_seen = 1'b1;
      pos_cnt = nalsc_pkg::HeaderPos;
    end else if (pos_cnt < nalsc_pkg::PosMax) begin
      pos_cnt = pos_cnt + 1'b1;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) parse_byte(s_axis_tdata_i);
    if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (rst_ni && byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= byte_q.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (passed_q.size() == 0) begin
        if (bad_cnt < 10)
          $display("unexpected item: data %h last %b", m_axis_tdata_o, m_axis_tlast_o);
        bad_cnt++;
      end else begin
        head_b = passed_q.pop_front();
        if (head_b.data !== m_axis_tdata_o || head_b.unit_end !== m_axis_tlast_o) begin
          if (bad_cnt < 10)
            $display("mismatch: expected data %h last %b, got data %h last %b",
                     head_b.data, head_b.unit_end, m_axis_tdata_o, m_axis_tlast_o);
          bad_cnt++;
        end
      end
    end
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic push_code();
    repeat (nalsc_pkg::CodeLen - 1) byte_q.push_back(nalsc_pkg::CodeZero);
    byte_q.push_back(nalsc_pkg::CodeOne);
  endtask

  task automatic write_reg(input logic [nalsc_pkg::CfgIdxW-1:0] idx,
                           input logic [nalsc_pkg::ByteW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == nalsc_pkg::CfgPps) pps_reg = val;
    else sps_reg = val;
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || s_axis_tvalid_i || passed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [nalsc_pkg::ByteW-1:0] pps,
                           input logic [nalsc_pkg::ByteW-1:0] sps,
                           input int send_pct, input int recv_pct, input int sps_pct,
                           input int n_bytes);
    int                          pick;
    logic [nalsc_pkg::ByteW-1:0] rnd;
    write_reg(nalsc_pkg::CfgPps, pps);
    write_reg(nalsc_pkg::CfgSps, sps);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (byte_q.size() < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        pick = $urandom_range(99);
        rnd  = byte_t'($urandom);
        push_code();
        byte_q.push_back((pick < 35) ? pps_reg : (pick < 35 + sps_pct) ? sps_reg : rnd);
        repeat ($urandom_range(10)) begin
          rnd = byte_t'($urandom);
          byte_q.push_back(($urandom_range(7) == 0) ? nalsc_pkg::CodeZero : rnd);
        end
      end else if (pick < 90) begin
        // one zero too many, the naive matcher misses this code
        repeat (nalsc_pkg::CodeLen) byte_q.push_back(nalsc_pkg::CodeZero);
        byte_q.push_back(nalsc_pkg::CodeOne);
      end else if (pick < 95) begin
        repeat (nalsc_pkg::CodeLen - 2) byte_q.push_back(nalsc_pkg::CodeZero);
        byte_q.push_back(nalsc_pkg::CodeOne);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          rnd = byte_t'($urandom);
          byte_q.push_back(rnd);
        end
      end
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // leading text whose fifth byte is the pps header, then the first start code
    byte_q = '{8'hFF, 8'h80, 8'h7F, 8'h55, nalsc_pkg::PpsReset};
    push_code();
    repeat (nalsc_pkg::CodeLen) byte_q.push_back(nalsc_pkg::CodeZero);
    byte_q.push_back(nalsc_pkg::CodeOne);
    push_code();
    byte_q.push_back(8'h13);
    byte_q.push_back(8'hFE);
    push_code();
    // sps unit left open across the register change
    byte_q.push_back(nalsc_pkg::SpsReset);
    byte_q.push_back(8'h42);
    drain();

    run_phase(8'hFF, 8'h00, 46, 0, 0, 250);
    run_phase(8'h00, 8'hFF, 0, 46, 8, 250);
    run_phase(8'h5A, 8'h5A, 20, 20, 10, 250);
    run_phase(nalsc_pkg::SpsReset, nalsc_pkg::PpsReset, 0, 0, 10, 250);

    if (bad_cnt == 0 && passed_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
